### src/lse_pkg.sv
`default_nettype none

package lse_pkg;

  localparam int SYM_W           = 9;
  localparam int CODE_OUT_W      = 12;
  localparam int CFG_W           = 9;

  localparam int CODE_LIMIT_DEF  = 4096;
  localparam int SYMBOL_BITS_DEF = 8;

  localparam logic [CFG_W-1:0] CLEAR_CODE_RST = 9'd256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_NODE,
    ST_EMIT,
    ST_WIPE
  } state_t;

  typedef struct packed {
    logic head_re;
    logic head_we;
    logic dict_re;
    logic dict_we;
  } mem_ctl_t;

endpackage

`default_nettype wire

### src/lse_sym_if.sv
`default_nettype none

interface lse_sym_if;
  logic                      valid;
  logic                      ready;
  logic [lse_pkg::SYM_W-1:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

`default_nettype wire

### src/lse_code_if.sv
`default_nettype none

interface lse_code_if;
  logic                           valid;
  logic                           ready;
  logic [lse_pkg::CODE_OUT_W-1:0] code_out;

  modport source (output valid, output code_out, input ready);
  modport sink   (input valid, input code_out, output ready);
endinterface

`default_nettype wire

### src/lzw_symbol_encoder.sv
// LZW symbol encoder: dictionary and code stream of a GIF-style LZW coder.
// Input channel sym_ch carries one symbol per transfer; a symbol equal to clear_code
// flushes the pending prefix code and empties the dictionary. Output channel code_ch
// carries each finished prefix code (low 12 bits). Symbols at or above clear_code + 1,
// or not below 2**SYMBOL_BITS, are dropped.
// cfg_we/cfg_data write clear_code; a write empties the dictionary and drops the prefix.
// Lookup hashes (prefix, symbol) into a bucket head table; buckets chain through the
// dictionary memory. A lookup is accepted in idle, reads the bucket head, then visits
// the chain one entry per node step, and passes through an emit step if a code goes out.
// A root or stray symbol is taken in idle alone, and so is a clear unless a prefix is
// pending, when it also goes through the emit step. The emit step loads the output
// register when it is free. RAM reads are registered, so each lookup step is its own state.
// Reset (rst, synchronous) sets clear_code to 256 and empties the dictionary; entries
// are qualified by their code range. After reset the bucket head table is cleared in
// one pass over all 2**CODE_BITS heads (4096 by default) while sym_ch.ready stays low.
// A result waits in an output register; while it is stalled, further symbols are still
// taken, and the block holds only when a second code is ready before the first leaves.
`default_nettype none

module lzw_symbol_encoder #(
  parameter int CODE_LIMIT  = lse_pkg::CODE_LIMIT_DEF,
  parameter int SYMBOL_BITS = lse_pkg::SYMBOL_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  lse_sym_if.sink                        sym_ch,
  lse_code_if.source                     code_ch,
  input  wire logic                      cfg_we,
  input  wire logic [lse_pkg::CFG_W-1:0] cfg_data
);

  localparam int CODE_BITS = $clog2(CODE_LIMIT);
  localparam int DICT_W    = 2 * CODE_BITS + SYMBOL_BITS + 1;

  lse_pkg::mem_ctl_t    ctl;
  logic [CODE_BITS-1:0] head_raddr, head_waddr, head_wdata, head_rdata;
  logic [CODE_BITS-1:0] dict_raddr, dict_waddr;
  logic [DICT_W-1:0]    dict_wdata, dict_rdata;

  lse_ctrl #(
    .CODE_LIMIT  (CODE_LIMIT),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .sym_ch     (sym_ch),
    .code_ch    (code_ch),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .ctl        (ctl),
    .head_raddr (head_raddr),
    .head_waddr (head_waddr),
    .head_wdata (head_wdata),
    .head_rdata (head_rdata),
    .dict_raddr (dict_raddr),
    .dict_waddr (dict_waddr),
    .dict_wdata (dict_wdata),
    .dict_rdata (dict_rdata)
  );

  lse_tables #(
    .CODE_LIMIT  (CODE_LIMIT),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_tables (
    .clk        (clk),
    .ctl        (ctl),
    .head_raddr (head_raddr),
    .head_waddr (head_waddr),
    .head_wdata (head_wdata),
    .head_rdata (head_rdata),
    .dict_raddr (dict_raddr),
    .dict_waddr (dict_waddr),
    .dict_wdata (dict_wdata),
    .dict_rdata (dict_rdata)
  );

endmodule

`default_nettype wire

### src/lse_tables.sv
`default_nettype none

// Bucket head table and dictionary, both with one write and one registered read port.
module lse_tables #(
  parameter int CODE_LIMIT  = lse_pkg::CODE_LIMIT_DEF,
  parameter int SYMBOL_BITS = lse_pkg::SYMBOL_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire lse_pkg::mem_ctl_t      ctl,
  input  wire logic [$clog2(CODE_LIMIT)-1:0] head_raddr,
  input  wire logic [$clog2(CODE_LIMIT)-1:0] head_waddr,
  input  wire logic [$clog2(CODE_LIMIT)-1:0] head_wdata,
  output logic      [$clog2(CODE_LIMIT)-1:0] head_rdata,
  input  wire logic [$clog2(CODE_LIMIT)-1:0] dict_raddr,
  input  wire logic [$clog2(CODE_LIMIT)-1:0] dict_waddr,
  input  wire logic [2*$clog2(CODE_LIMIT)+SYMBOL_BITS:0] dict_wdata,
  output logic      [2*$clog2(CODE_LIMIT)+SYMBOL_BITS:0] dict_rdata
);

  localparam int CODE_BITS  = $clog2(CODE_LIMIT);
  localparam int HEAD_DEPTH = 1 << CODE_BITS;
  localparam int DICT_W     = 2 * CODE_BITS + SYMBOL_BITS + 1;

  logic [CODE_BITS-1:0] head_mem [HEAD_DEPTH];
  logic [DICT_W-1:0]    dict_mem [CODE_LIMIT];

  always_ff @(posedge clk) begin
    if (ctl.head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (ctl.head_re) begin
      head_rdata <= head_mem[head_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.dict_we) begin
      dict_mem[dict_waddr] <= dict_wdata;
    end
    if (ctl.dict_re) begin
      dict_rdata <= dict_mem[dict_raddr];
    end
  end

endmodule

`default_nettype wire

### src/lse_ctrl.sv
`default_nettype none

// Sequencer: hashed lookup through the bucket chain, insert on miss, result register.
// An entry counts only if its code lies in [clear_code+2, next free code), so a clear
// needs no sweep of the tables. A bucket head is trusted only if the entry it names
// hashes back to the same bucket. After reset the bucket heads are swept once to
// code 0, which is never live.
module lse_ctrl #(
  parameter int CODE_LIMIT  = lse_pkg::CODE_LIMIT_DEF,
  parameter int SYMBOL_BITS = lse_pkg::SYMBOL_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  lse_sym_if.sink                     sym_ch,
  lse_code_if.source                  code_ch,
  input  wire logic                   cfg_we,
  input  wire logic [lse_pkg::CFG_W-1:0] cfg_data,
  output lse_pkg::mem_ctl_t           ctl,
  output logic [$clog2(CODE_LIMIT)-1:0] head_raddr,
  output logic [$clog2(CODE_LIMIT)-1:0] head_waddr,
  output logic [$clog2(CODE_LIMIT)-1:0] head_wdata,
  input  wire logic [$clog2(CODE_LIMIT)-1:0] head_rdata,
  output logic [$clog2(CODE_LIMIT)-1:0] dict_raddr,
  output logic [$clog2(CODE_LIMIT)-1:0] dict_waddr,
  output logic [2*$clog2(CODE_LIMIT)+SYMBOL_BITS:0] dict_wdata,
  input  wire logic [2*$clog2(CODE_LIMIT)+SYMBOL_BITS:0] dict_rdata
);

  localparam int CODE_BITS  = $clog2(CODE_LIMIT);
  localparam int NFC_BITS   = CODE_BITS + 1;
  localparam int DICT_W     = 2 * CODE_BITS + SYMBOL_BITS + 1;
  localparam int HASH_SHIFT = CODE_BITS - SYMBOL_BITS;
  localparam logic [NFC_BITS-1:0] LIMIT = NFC_BITS'(CODE_LIMIT);

  function automatic logic [CODE_BITS-1:0] key_hash(input logic [CODE_BITS-1:0]   p,
                                                     input logic [SYMBOL_BITS-1:0] s);
    return p ^ {s, {HASH_SHIFT{1'b0}}};
  endfunction

  lse_pkg::state_t state, state_next;

  logic [lse_pkg::CFG_W-1:0]      clear_code;
  logic [NFC_BITS-1:0]            nfc;
  logic [CODE_BITS-1:0]           prefix;
  logic                           pvalid;
  logic [SYMBOL_BITS-1:0]         sym_r;
  logic [CODE_BITS-1:0]           hash_r;
  logic [CODE_BITS-1:0]           cur;
  logic [CODE_BITS-1:0]           head_c;
  logic                           chk_hash;
  logic [CODE_BITS-1:0]           pend;
  logic                           out_valid;
  logic [lse_pkg::CODE_OUT_W-1:0] out_code;
  logic [CODE_BITS-1:0]           wipe_addr;

  logic [lse_pkg::SYM_W-1:0] sym;
  logic [SYMBOL_BITS-1:0]    sym_lo;
  logic                      acc, is_clear, is_stray, acc_clear, acc_root, start_lookup;
  logic [NFC_BITS-1:0]       base;
  logic                      room, live_c;
  logic [CODE_BITS-1:0]      d_prefix, d_nxt;
  logic [SYMBOL_BITS-1:0]    d_sym;
  logic                      d_nv, key_hit, head_bad;
  logic                      node_hit, node_next, node_miss, miss, link, slot_free;

  assign sym      = sym_ch.symbol;
  assign sym_lo   = sym[SYMBOL_BITS-1:0];
  assign acc      = sym_ch.valid && sym_ch.ready;
  assign is_clear = (sym == clear_code);
  assign is_stray = (sym > clear_code) || ((sym >> SYMBOL_BITS) != '0);

  assign acc_clear    = acc && is_clear;
  assign acc_root     = acc && !is_clear && !is_stray && !pvalid;
  assign start_lookup = acc && !is_clear && !is_stray && pvalid;

  assign base   = NFC_BITS'(clear_code) + NFC_BITS'(2);
  assign room   = (nfc < LIMIT);
  assign live_c = (NFC_BITS'(head_rdata) >= base) && (NFC_BITS'(head_rdata) < nfc)
                  && (NFC_BITS'(head_rdata) < LIMIT);

  // entry layout: {prefix, symbol, next valid, next code}
  assign d_prefix = dict_rdata[DICT_W-1 -: CODE_BITS];
  assign d_sym    = dict_rdata[CODE_BITS+1 +: SYMBOL_BITS];
  assign d_nv     = dict_rdata[CODE_BITS];
  assign d_nxt    = dict_rdata[CODE_BITS-1:0];

  assign key_hit  = (d_prefix == prefix) && (d_sym == sym_r);
  assign head_bad = chk_hash && (key_hash(d_prefix, d_sym) != hash_r);

  assign node_hit  = !head_bad && key_hit;
  assign node_next = !head_bad && !key_hit && d_nv;
  assign node_miss = head_bad || (!key_hit && !d_nv);

  assign miss = ((state == lse_pkg::ST_HEAD) && !live_c) ||
                ((state == lse_pkg::ST_NODE) && node_miss);
  // a chain walked without a bad head means the head is current: link the new entry to it
  assign link = (state == lse_pkg::ST_NODE) && !head_bad;

  assign slot_free = !out_valid || code_ch.ready;

  always_comb begin
    state_next = state;
    case (state)
      lse_pkg::ST_IDLE: begin
        if (acc_clear) begin
          state_next = pvalid ? lse_pkg::ST_EMIT : lse_pkg::ST_IDLE;
        end else if (start_lookup) begin
          state_next = lse_pkg::ST_HEAD;
        end
      end
      lse_pkg::ST_HEAD: begin
        state_next = live_c ? lse_pkg::ST_NODE : lse_pkg::ST_EMIT;
      end
      lse_pkg::ST_NODE: begin
        if (node_hit) begin
          state_next = lse_pkg::ST_IDLE;
        end else if (node_next) begin
          state_next = lse_pkg::ST_NODE;
        end else begin
          state_next = lse_pkg::ST_EMIT;
        end
      end
      lse_pkg::ST_EMIT: begin
        if (slot_free) begin
          state_next = lse_pkg::ST_IDLE;
        end
      end
      lse_pkg::ST_WIPE: begin
        if (wipe_addr == {CODE_BITS{1'b1}}) begin
          state_next = lse_pkg::ST_IDLE;
        end
      end
      default: state_next = lse_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sym_ch.ready = 1'b0;
    ctl          = '0;
    head_raddr   = key_hash(prefix, sym_lo);
    dict_raddr   = head_rdata;
    head_waddr   = hash_r;
    head_wdata   = nfc[CODE_BITS-1:0];
    dict_waddr   = nfc[CODE_BITS-1:0];
    dict_wdata   = {prefix, sym_r, link, link ? head_c : {CODE_BITS{1'b0}}};
    case (state)
      lse_pkg::ST_IDLE: begin
        sym_ch.ready = 1'b1;
        ctl.head_re  = start_lookup;
      end
      lse_pkg::ST_HEAD: begin
        ctl.dict_re = live_c;
        ctl.head_we = !live_c && room;
        ctl.dict_we = !live_c && room;
      end
      lse_pkg::ST_NODE: begin
        dict_raddr  = d_nxt;
        ctl.dict_re = node_next;
        ctl.head_we = node_miss && room;
        ctl.dict_we = node_miss && room;
      end
      lse_pkg::ST_EMIT: begin
        sym_ch.ready = 1'b0;
      end
      lse_pkg::ST_WIPE: begin
        head_waddr  = wipe_addr;
        head_wdata  = '0;
        ctl.head_we = 1'b1;
      end
      default: begin
        sym_ch.ready = 1'b0;
      end
    endcase
  end

  assign code_ch.valid    = out_valid;
  assign code_ch.code_out = out_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lse_pkg::ST_WIPE;
      wipe_addr  <= '0;
      clear_code <= lse_pkg::CLEAR_CODE_RST;
      nfc        <= NFC_BITS'(lse_pkg::CLEAR_CODE_RST) + NFC_BITS'(2);
      prefix     <= '0;
      pvalid     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == lse_pkg::ST_WIPE) begin
        wipe_addr <= wipe_addr + CODE_BITS'(1);
      end
      if (cfg_we) begin
        clear_code <= cfg_data;
        nfc        <= NFC_BITS'(cfg_data) + NFC_BITS'(2);
        prefix     <= '0;
        pvalid     <= 1'b0;
      end else if ((state == lse_pkg::ST_IDLE) && acc_clear) begin
        nfc    <= base;
        prefix <= '0;
        pvalid <= 1'b0;
      end else if ((state == lse_pkg::ST_IDLE) && acc_root) begin
        prefix <= CODE_BITS'(sym_lo);
        pvalid <= 1'b1;
      end else if ((state == lse_pkg::ST_NODE) && node_hit) begin
        prefix <= cur;
      end else if (miss) begin
        prefix <= CODE_BITS'(sym_r);
        if (room) begin
          nfc <= nfc + NFC_BITS'(1);
        end
      end
      if ((state == lse_pkg::ST_EMIT) && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && code_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == lse_pkg::ST_IDLE) && (acc_clear || start_lookup)) begin
      pend <= prefix;
    end
    if (start_lookup) begin
      sym_r  <= sym_lo;
      hash_r <= key_hash(prefix, sym_lo);
    end
    if ((state == lse_pkg::ST_HEAD) && live_c) begin
      cur      <= head_rdata;
      head_c   <= head_rdata;
      chk_hash <= 1'b1;
    end else if ((state == lse_pkg::ST_NODE) && node_next) begin
      cur      <= d_nxt;
      chk_hash <= 1'b0;
    end
    if ((state == lse_pkg::ST_EMIT) && slot_free) begin
      out_code <= lse_pkg::CODE_OUT_W'(pend);
    end
  end

  assert property (@(posedge clk) disable iff (rst) nfc >= base)
    else $error("free code below first dictionary code");

  assert property (@(posedge clk) disable iff (rst) ctl.dict_we |-> (nfc < LIMIT))
    else $error("dictionary insert with no room");

  assert property (@(posedge clk) disable iff (rst)
                   (state != lse_pkg::ST_WIPE) |-> (ctl.dict_we == ctl.head_we))
    else $error("bucket head and entry written apart");

  assert property (@(posedge clk) disable iff (rst)
                   ctl.dict_re |-> (NFC_BITS'(dict_raddr) < nfc))
    else $error("dictionary read beyond live codes");

  assert property (@(posedge clk) disable iff (rst)
                   $fell(pvalid) |-> ($past(cfg_we) || $past(acc_clear)))
    else $error("prefix dropped without clear");

endmodule

`default_nettype wire

### tb/tb.sv
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SYM_W           = lse_pkg::SYM_W;
  localparam int CODE_OUT_W      = lse_pkg::CODE_OUT_W;
  localparam int CFG_W           = lse_pkg::CFG_W;
  localparam int SYMBOL_BITS_DEF = lse_pkg::SYMBOL_BITS_DEF;
  localparam int CODE_LIMIT_DEF  = lse_pkg::CODE_LIMIT_DEF;
  localparam logic [lse_pkg::CFG_W-1:0] CLEAR_CODE_RST = lse_pkg::CLEAR_CODE_RST;

  localparam int SYM_SPAN      = 1 << SYMBOL_BITS_DEF;
  localparam int SYM_MAX       = (1 << SYM_W) - 1;
  localparam int KEY_W         = CODE_OUT_W + SYMBOL_BITS_DEF;

  // Tracks the dictionary and prefix, and queues the codes it expects on code_ch.
  class lzw_scoreboard;
    logic [CFG_W-1:0]      clear_code;
    bit [CODE_OUT_W-1:0]   code_of [bit [KEY_W-1:0]];
    int unsigned           next_code;
    bit [CODE_OUT_W-1:0]   prefix;
    bit                    has_prefix;
    bit [CODE_OUT_W-1:0]   code_q [$];
    int                    n_bad;

    function new();
      n_bad = 0;
      set_clear_code(CLEAR_CODE_RST);
    endfunction

    // Also used on a clear symbol: same effect minus the register change.
    function void set_clear_code(input logic [CFG_W-1:0] v);
      clear_code = v;
      next_code  = v + 2;
      prefix     = '0;
      has_prefix = 1'b0;
      code_of.delete();
    endfunction

    function void note_symbol(input logic [SYM_W-1:0] s);
      bit [KEY_W-1:0] key;
      if (s == clear_code) begin
        if (has_prefix) code_q.push_back(prefix);
        set_clear_code(clear_code);
        return;
      end
      if (s > clear_code || s >= SYM_SPAN) return;
      if (!has_prefix) begin
        prefix     = CODE_OUT_W'(s);
        has_prefix = 1'b1;
        return;
      end
      key = {prefix, s[SYMBOL_BITS_DEF-1:0]};
      if (code_of.exists(key)) begin
        prefix = code_of[key];
        return;
      end
      code_q.push_back(prefix);
      if (next_code < CODE_LIMIT_DEF) begin
        code_of[key] = next_code[CODE_OUT_W-1:0];
        next_code++;
      end
      prefix = CODE_OUT_W'(s);
    endfunction

    function void check_code(input logic [CODE_OUT_W-1:0] got);
      bit [CODE_OUT_W-1:0] want;
      if (code_q.size() == 0) begin
        n_bad++;
        $display("%0t: code_out with nothing pending: expected none, actual %0d", $time, got);
        return;
      end
      want = code_q.pop_front();
      if (got !== want) begin
        n_bad++;
        $display("%0t: code_out mismatch: expected %0d, actual %0d", $time, want, got);
      end
    endfunction

    function bit busy();
      return code_q.size() != 0;
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;
  bit               no_idle;
  int               stall_left;
  lzw_scoreboard    sb;

  lse_sym_if  sym_ch ();
  lse_code_if code_ch ();

  lzw_symbol_encoder u_top (
    .clk      (clk),
    .rst      (rst),
    .sym_ch   (sym_ch),
    .code_ch  (code_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // opening sequence under the reset clear code
  logic [SYM_W-1:0] opening [18] = '{
    CLEAR_CODE_RST, 9'd0, 9'd0, 9'd0, 9'd0, 9'd255, 9'd255, CLEAR_CODE_RST + 9'd1,
    9'd300, 9'd511, 9'd255, 9'd128, CLEAR_CODE_RST, 9'd65, 9'd66, 9'd65, 9'd66, 9'd65
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // code sink: random stalls, about 7% of the time, none while no_idle is set
  always @(posedge clk) begin
    if (rst) begin
      code_ch.ready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (code_ch.valid && code_ch.ready) sb.check_code(code_ch.code_out);
      if (stall_left != 0) begin
        stall_left    <= stall_left - 1;
        code_ch.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(99) < 3) begin
        stall_left    <= $urandom_range(3);
        code_ch.ready <= 1'b0;
      end else begin
        code_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_symbol(input logic [SYM_W-1:0] s);
    int r;
    r = $urandom_range(999);
    if (!no_idle && r < 70) begin
      sym_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end else if (!no_idle && r < 80) begin
      // hold off until the code stream has caught up
      sym_ch.valid <= 1'b0;
      do @(posedge clk); while (sb.busy());
    end
    sym_ch.valid  <= 1'b1;
    sym_ch.symbol <= s;
    do @(posedge clk); while (!sym_ch.ready);
    sb.note_symbol(s);
  endtask

  // Symbols that emit nothing may still be in flight once the queue is empty;
  // the block is idle once it shows ready with nothing offered.
  task automatic drain();
    sym_ch.valid <= 1'b0;
    while (sb.busy()) @(posedge clk);
    do @(posedge clk); while (!sym_ch.ready);
  endtask

  task automatic write_clear_code(input logic [CFG_W-1:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.set_clear_code(v);
  endtask

  // Mostly symbols from a window of alpha values in the valid range, so strings grow long;
  // the rest are clear symbols and arbitrary 9-bit values.
  task automatic run_random(input int n, input int alpha, input int clear_pct);
    int lim;
    int width;
    int base;
    int r;
    logic [SYM_W-1:0] s;
    lim   = (sb.clear_code < SYM_SPAN) ? int'(sb.clear_code) : SYM_SPAN;
    width = (alpha < lim) ? alpha : lim;
    base  = (lim > width) ? $urandom_range(lim - width) : 0;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < clear_pct) s = sb.clear_code;
      else if (r < clear_pct + 6 || lim == 0) s = SYM_W'($urandom_range(SYM_MAX));
      else s = SYM_W'(base + $urandom_range(width - 1));
      send_symbol(s);
    end
  endtask

  initial begin
    sb            = new();
    no_idle       = 1'b0;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_data      <= '0;
    sym_ch.valid  <= 1'b0;
    sym_ch.symbol <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening[i]) send_symbol(opening[i]);

    // smallest regular clear code: two symbols, clear, and the stray one above it
    write_clear_code(9'd2);
    send_symbol(9'd0);
    send_symbol(9'd1);
    send_symbol(9'd2);
    send_symbol(9'd3);
    send_symbol(9'd1);

    write_clear_code(CLEAR_CODE_RST);
    run_random(150, 4, 3);
    write_clear_code(9'd2);
    run_random(80, 2, 3);
    write_clear_code(9'd1);
    run_random(60, 1, 3);
    write_clear_code(9'd0);
    run_random(30, 1, 10);
    write_clear_code(9'd511);
    run_random(150, SYM_SPAN, 2);
    write_clear_code(9'd257);
    run_random(120, 3, 3);
    write_clear_code(CFG_W'($urandom_range(3, 255)));
    run_random(150, 8, 3);

    no_idle = 1'b1;
    write_clear_code(CLEAR_CODE_RST);
    run_random(200, 16, 2);
    no_idle = 1'b0;

    drain();
    if (sb.n_bad == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
